// ===== rtl/fsc_pkg.sv =====
package fsc_pkg;

  // Default grid size
  localparam int GridRows    = 64;
  localparam int GridColumns = 64;

  // Fixed field widths
  localparam int CmdW     = 2;
  localparam int CoordInW = 6;
  localparam int MatW     = 2;
  localparam int DensW    = 8;
  localparam int NibW     = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  // Signed working width for target coordinates (holds -2048 .. 2047)
  localparam int CoordW = 12;

  // Candidate counter: three falling targets plus two per spread offset
  localparam int CandW        = 6;
  localparam int NumFallCand  = 3;

  typedef enum logic [CmdW-1:0] {
    CmdWrite  = 2'd0,
    CmdRead   = 2'd1,
    CmdUpdate = 2'd2,
    CmdSpare  = 2'd3
  } cmd_e;

  typedef enum logic [MatW-1:0] {
    MatEmpty = 2'd0,
    MatSand  = 2'd1,
    MatWater = 2'd2,
    MatSolid = 2'd3
  } mat_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDensSand  = 3'd0,
    CfgDensWater = 3'd1,
    CfgDensSolid = 3'd2,
    CfgStatMask  = 3'd3,
    CfgSpread    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DensW-1:0] density_sand;
    logic [DensW-1:0] density_water;
    logic [DensW-1:0] density_solid;
    logic [NibW-1:0]  static_mask;
    logic [NibW-1:0]  water_spread;
  } cfg_t;

endpackage

// ===== rtl/fsc_cfg.sv =====
module fsc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fsc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fsc_pkg::CfgDataW-1:0]  cfg_data_i,
  output fsc_pkg::cfg_t                 cfg_o
);
  import fsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDensSand:  cfg_d.density_sand  = cfg_data_i[DensW-1:0];
        CfgDensWater: cfg_d.density_water = cfg_data_i[DensW-1:0];
        CfgDensSolid: cfg_d.density_solid = cfg_data_i[DensW-1:0];
        CfgStatMask:  cfg_d.static_mask   = cfg_data_i[NibW-1:0];
        CfgSpread:    cfg_d.water_spread  = cfg_data_i[NibW-1:0];
        default:      cfg_d = cfg_q;  // unknown index: drop
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.density_sand  <= DensW'(200);
      cfg_q.density_water <= DensW'(100);
      cfg_q.density_solid <= DensW'(255);
      cfg_q.static_mask   <= NibW'(8);
      cfg_q.water_spread  <= NibW'(4);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/fsc_grid_mem.sv =====
module fsc_grid_mem #(
  parameter int GRID_ROWS    = fsc_pkg::GridRows,
  parameter int GRID_COLUMNS = fsc_pkg::GridColumns,
  localparam int Depth       = GRID_ROWS * GRID_COLUMNS,
  localparam int AddrW       = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [fsc_pkg::MatW-1:0]  wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [fsc_pkg::MatW-1:0]  rdata_o,
  output logic                      clearing_o
);
  import fsc_pkg::*;

  logic [MatW-1:0]  mem [Depth];
  logic [MatW-1:0]  rdata_q;
  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [MatW-1:0]  mem_wdata;

  assign clearing_o = clr_q;
  assign rdata_o    = rdata_q;

  // Sweep zeros through the grid after reset, one cell a cycle
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  assign mem_we    = clr_q | we_i;
  assign mem_waddr = clr_q ? clr_cnt_q : waddr_i;
  assign mem_wdata = clr_q ? MatEmpty : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/fsc_ctrl.sv =====
module fsc_ctrl #(
  parameter int GRID_ROWS    = fsc_pkg::GridRows,
  parameter int GRID_COLUMNS = fsc_pkg::GridColumns,
  localparam int AddrW       = $clog2(GRID_ROWS * GRID_COLUMNS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsc_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fsc_pkg::CmdW-1:0]      command_i,
  input  logic [fsc_pkg::CoordInW-1:0]  row_i,
  input  logic [fsc_pkg::CoordInW-1:0]  column_i,
  input  logic [fsc_pkg::MatW-1:0]      material_i,
  input  logic                          side_choice_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fsc_pkg::MatW-1:0]      cell_material_o,
  output logic                          moved_o,
  output logic [fsc_pkg::CoordInW-1:0]  dest_row_o,
  output logic [fsc_pkg::CoordInW-1:0]  dest_column_o,
  input  logic                          clearing_i,
  output logic                          we_o,
  output logic [AddrW-1:0]              waddr_o,
  output logic [fsc_pkg::MatW-1:0]      wdata_o,
  output logic                          re_o,
  output logic [AddrW-1:0]              raddr_o,
  input  logic [fsc_pkg::MatW-1:0]      rdata_i
);
  import fsc_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StSelf  = 7'b0000010,
    StProbe = 7'b0000100,
    StCheck = 7'b0001000,
    StSwapA = 7'b0010000,
    StSwapB = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  typedef logic signed [CoordW-1:0] coord_t;

  function automatic logic in_grid(coord_t r, coord_t c);
    return (r >= 0) && (int'(r) < GRID_ROWS) && (c >= 0) && (int'(c) < GRID_COLUMNS);
  endfunction

  function automatic logic [AddrW-1:0] addr_of(coord_t r, coord_t c);
    return AddrW'(int'(r) * GRID_COLUMNS + int'(c));
  endfunction

  function automatic logic [DensW-1:0] dens_of(logic [MatW-1:0] m, cfg_t cfg);
    logic [DensW-1:0] d;
    unique case (m)
      MatSand:  d = cfg.density_sand;
      MatWater: d = cfg.density_water;
      MatSolid: d = cfg.density_solid;
      default:  d = '0;
    endcase
    return d;
  endfunction

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  logic [CmdW-1:0]     cmd_q, cmd_d;
  logic [MatW-1:0]     mat_q, mat_d;
  logic                side_q, side_d;
  coord_t              row_q, row_d, col_q, col_d;
  logic [AddrW-1:0]    self_addr_q, self_addr_d;
  coord_t              tgt_row_q, tgt_row_d, tgt_col_q, tgt_col_d;
  logic [AddrW-1:0]    tgt_addr_q, tgt_addr_d;
  logic [MatW-1:0]     tmat_q, tmat_d;
  logic [MatW-1:0]     prev_q, prev_d;
  logic                moved_q, moved_d;
  logic [CandW-1:0]    cand_q, cand_d;
  logic [CoordInW-1:0] dest_row_q, dest_row_d, dest_col_q, dest_col_d;
  logic [MatW-1:0]     o_mat_q, o_mat_d;
  logic                o_moved_q, o_moved_d;
  logic [CoordInW-1:0] o_row_q, o_row_d, o_col_q, o_col_d;

  coord_t           in_row, in_col;
  logic             in_fire, out_free;
  logic [CandW-1:0] cand_j, end_cnt;
  coord_t           cand_off, cand_row, cand_col;
  logic             cand_pos, move_ok;

  assign in_row   = coord_t'(row_i);
  assign in_col   = coord_t'(column_i);
  assign in_ready_o = (state_q == StIdle) && !clearing_i;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Candidate order: down, down toward side, down away, then row offsets
  assign cand_j   = cand_q - CandW'(NumFallCand);
  assign cand_off = coord_t'(cand_j[CandW-1:1]) + coord_t'(1);
  always_comb begin
    cand_row = row_q + coord_t'(1);
    cand_col = col_q;
    cand_pos = side_q;
    if (cand_q == CandW'(1)) begin
      cand_pos = side_q;
      cand_col = cand_pos ? col_q + coord_t'(1) : col_q - coord_t'(1);
    end else if (cand_q == CandW'(2)) begin
      cand_pos = !side_q;
      cand_col = cand_pos ? col_q + coord_t'(1) : col_q - coord_t'(1);
    end else if (cand_q >= CandW'(NumFallCand)) begin
      cand_row = row_q;
      cand_pos = side_q ^ cand_j[0];
      cand_col = cand_pos ? col_q + cand_off : col_q - cand_off;
    end
  end

  assign end_cnt = (prev_q == MatWater)
                 ? CandW'({cfg_i.water_spread, 1'b0}) + CandW'(NumFallCand)
                 : CandW'(NumFallCand);

  assign move_ok = (rdata_i == MatEmpty) ||
                   ((dens_of(prev_q, cfg_i) > dens_of(rdata_i, cfg_i)) &&
                    !cfg_i.static_mask[rdata_i]);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_d       = cmd_q;
    mat_d       = mat_q;
    side_d      = side_q;
    row_d       = row_q;
    col_d       = col_q;
    self_addr_d = self_addr_q;
    tgt_row_d   = tgt_row_q;
    tgt_col_d   = tgt_col_q;
    tgt_addr_d  = tgt_addr_q;
    tmat_d      = tmat_q;
    prev_d      = prev_q;
    moved_d     = moved_q;
    cand_d      = cand_q;
    dest_row_d  = dest_row_q;
    dest_col_d  = dest_col_q;
    o_mat_d     = o_mat_q;
    o_moved_d   = o_moved_q;
    o_row_d     = o_row_q;
    o_col_d     = o_col_q;
    we_o        = 1'b0;
    waddr_o     = self_addr_q;
    wdata_o     = mat_q;
    re_o        = 1'b0;
    raddr_o     = addr_of(in_row, in_col);

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          cmd_d       = command_i;
          mat_d       = material_i;
          side_d      = side_choice_i;
          row_d       = in_row;
          col_d       = in_col;
          self_addr_d = addr_of(in_row, in_col);
          dest_row_d  = row_i;
          dest_col_d  = column_i;
          moved_d     = 1'b0;
          prev_d      = MatEmpty;
          if (in_grid(in_row, in_col)) begin
            re_o    = 1'b1;
            state_d = StSelf;
          end else begin
            state_d = StDone;
          end
        end
      end
      StSelf: begin
        prev_d  = rdata_i;
        cand_d  = '0;
        state_d = StDone;
        unique case (cmd_q)
          CmdWrite: begin
            we_o = 1'b1;
          end
          CmdUpdate: begin
            if (rdata_i == MatSand || rdata_i == MatWater) begin
              state_d = StProbe;
            end
          end
          default: ;
        endcase
      end
      StProbe: begin
        if (cand_q == end_cnt) begin
          state_d = StDone;
        end else if (in_grid(cand_row, cand_col)) begin
          re_o       = 1'b1;
          raddr_o    = addr_of(cand_row, cand_col);
          tgt_addr_d = addr_of(cand_row, cand_col);
          tgt_row_d  = cand_row;
          tgt_col_d  = cand_col;
          state_d    = StCheck;
        end else begin
          cand_d = cand_q + CandW'(1);
        end
      end
      StCheck: begin
        if (move_ok) begin
          tmat_d  = rdata_i;
          state_d = StSwapA;
        end else begin
          cand_d  = cand_q + CandW'(1);
          state_d = StProbe;
        end
      end
      StSwapA: begin
        we_o    = 1'b1;
        waddr_o = tgt_addr_q;
        wdata_o = prev_q;
        state_d = StSwapB;
      end
      StSwapB: begin
        we_o       = 1'b1;
        waddr_o    = self_addr_q;
        wdata_o    = tmat_q;
        moved_d    = 1'b1;
        dest_row_d = tgt_row_q[CoordInW-1:0];
        dest_col_d = tgt_col_q[CoordInW-1:0];
        state_d    = StDone;
      end
      StDone: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          o_mat_d     = prev_q;
          o_moved_d   = moved_q;
          o_row_d     = dest_row_q;
          o_col_d     = dest_col_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    mat_q       <= mat_d;
    side_q      <= side_d;
    row_q       <= row_d;
    col_q       <= col_d;
    self_addr_q <= self_addr_d;
    tgt_row_q   <= tgt_row_d;
    tgt_col_q   <= tgt_col_d;
    tgt_addr_q  <= tgt_addr_d;
    tmat_q      <= tmat_d;
    prev_q      <= prev_d;
    moved_q     <= moved_d;
    cand_q      <= cand_d;
    dest_row_q  <= dest_row_d;
    dest_col_q  <= dest_col_d;
    o_mat_q     <= o_mat_d;
    o_moved_q   <= o_moved_d;
    o_row_q     <= o_row_d;
    o_col_q     <= o_col_d;
  end

  assign out_valid_o     = out_valid_q;
  assign cell_material_o = o_mat_q;
  assign moved_o         = o_moved_q;
  assign dest_row_o      = o_row_q;
  assign dest_column_o   = o_col_q;

  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_i |-> !we_o)
    else $error("grid write issued during clearing pass");

  a_swap_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSwapA) |=> (state_q == StSwapB))
    else $error("swap did not complete its second write");

  a_moved_is_fluid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && moved_o) |-> (cell_material_o == MatSand || cell_material_o == MatWater))
    else $error("moved result for a material that cannot move");

  a_idle_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StSelf || state_q == StDone))
    else $error("accepted item did not start its sequence");

endmodule

// ===== rtl/falling_sand_cell_update.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    command_i row_i column_i material_i side_choice_i
// out      output     out_valid_o / out_ready_i  cell_material_o moved_o dest_row_o dest_column_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i cfg_data_i
//
// One item at a time; a read or write of an address outside the grid skips the grid memory.
// An update reads the cell; for sand or water it then reads each candidate target inside
// the grid, skipping targets outside it, and swaps the two cells when a move is allowed.
// After reset a clearing pass writes zeros to all GRID_ROWS*GRID_COLUMNS cells;
// in_ready_o stays low meanwhile, configuration writes are taken throughout.
// A finished result waits in the output register until taken.
module falling_sand_cell_update #(
  parameter int GRID_ROWS    = fsc_pkg::GridRows,
  parameter int GRID_COLUMNS = fsc_pkg::GridColumns
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fsc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fsc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fsc_pkg::CmdW-1:0]      command_i,
  input  logic [fsc_pkg::CoordInW-1:0]  row_i,
  input  logic [fsc_pkg::CoordInW-1:0]  column_i,
  input  logic [fsc_pkg::MatW-1:0]      material_i,
  input  logic                          side_choice_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fsc_pkg::MatW-1:0]      cell_material_o,
  output logic                          moved_o,
  output logic [fsc_pkg::CoordInW-1:0]  dest_row_o,
  output logic [fsc_pkg::CoordInW-1:0]  dest_column_o
);
  import fsc_pkg::*;

  localparam int AddrW = $clog2(GRID_ROWS * GRID_COLUMNS);

  cfg_t             cfg;
  logic             clearing;
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [MatW-1:0]  wdata, rdata;

  fsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fsc_grid_mem #(
    .GRID_ROWS    (GRID_ROWS),
    .GRID_COLUMNS (GRID_COLUMNS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (we),
    .waddr_i    (waddr),
    .wdata_i    (wdata),
    .re_i       (re),
    .raddr_i    (raddr),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  fsc_ctrl #(
    .GRID_ROWS    (GRID_ROWS),
    .GRID_COLUMNS (GRID_COLUMNS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .row_i           (row_i),
    .column_i        (column_i),
    .material_i      (material_i),
    .side_choice_i   (side_choice_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cell_material_o (cell_material_o),
    .moved_o         (moved_o),
    .dest_row_o      (dest_row_o),
    .dest_column_o   (dest_column_o),
    .clearing_i      (clearing),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .re_o            (re),
    .raddr_o         (raddr),
    .rdata_i         (rdata)
  );

endmodule

// ===== sim/falling_sand_cell_update_tb.sv =====
`timescale 1ns / 1ps

module falling_sand_cell_update_tb;
  import fsc_pkg::*;

  typedef struct {
    mat_e                cell_material;
    logic                moved;
    logic [CoordInW-1:0] dest_row;
    logic [CoordInW-1:0] dest_column;
  } outcome_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [CmdW-1:0]     command_i     = '0;
  logic [CoordInW-1:0] row_i         = '0;
  logic [CoordInW-1:0] column_i      = '0;
  logic [MatW-1:0]     material_i    = '0;
  logic                side_choice_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [MatW-1:0]     cell_material_o;
  logic                moved_o;
  logic [CoordInW-1:0] dest_row_o;
  logic [CoordInW-1:0] dest_column_o;

  // Shadow copy of the grid and the configuration registers
  mat_e            grid_model [GridRows][GridColumns];
  logic [DensW-1:0] sand_density  = 8'd200;
  logic [DensW-1:0] water_density = 8'd100;
  logic [DensW-1:0] solid_density = 8'd255;
  logic [NibW-1:0]  pinned_mask   = 4'd8;
  logic [NibW-1:0]  spread_limit  = 4'd4;

  outcome_t    outcome_q [$];
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int          errors    = 0;

  falling_sand_cell_update dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .material_i     (material_i),
    .side_choice_i  (side_choice_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_material_o(cell_material_o),
    .moved_o        (moved_o),
    .dest_row_o     (dest_row_o),
    .dest_column_o  (dest_column_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DensW-1:0] density_of_mat(mat_e m);
    case (m)
      MatSand:  return sand_density;
      MatWater: return water_density;
      MatSolid: return solid_density;
      default:  return '0;
    endcase
  endfunction

  function automatic bit swap_if_allowed(int r, int c, int r2, int c2);
    mat_e mover;
    mat_e target;
    if (r2 < 0 || r2 >= GridRows || c2 < 0 || c2 >= GridColumns) return 1'b0;
    mover  = grid_model[r][c];
    target = grid_model[r2][c2];
    if (target != MatEmpty &&
        (density_of_mat(mover) <= density_of_mat(target) || pinned_mask[target]))
      return 1'b0;
    grid_model[r][c]   = target;
    grid_model[r2][c2] = mover;
    return 1'b1;
  endfunction

  // Apply one command to the shadow grid and return the result it yields
  function automatic outcome_t apply_command(cmd_e cmd, int r, int c, mat_e mat, logic side);
    outcome_t res;
    int       dir;
    int       tc;
    res.cell_material = grid_model[r][c];
    res.moved         = 1'b0;
    res.dest_row      = CoordInW'(r);
    res.dest_column   = CoordInW'(c);
    dir = side ? 1 : -1;
    if (cmd == CmdWrite) begin
      grid_model[r][c] = mat;
    end else if (cmd == CmdUpdate &&
                 (res.cell_material == MatSand || res.cell_material == MatWater)) begin
      for (int k = 0; k < NumFallCand && !res.moved; k++) begin
        tc = (k == 0) ? c : (k == 1) ? c + dir : c - dir;
        if (swap_if_allowed(r, c, r + 1, tc)) begin
          res.moved       = 1'b1;
          res.dest_row    = CoordInW'(r + 1);
          res.dest_column = CoordInW'(tc);
        end
      end
      if (res.cell_material == MatWater) begin
        for (int i = 1; i <= int'(spread_limit) && !res.moved; i++) begin
          for (int j = 0; j < 2 && !res.moved; j++) begin
            tc = (j == 0) ? c + dir * i : c - dir * i;
            if (swap_if_allowed(r, c, r, tc)) begin
              res.moved       = 1'b1;
              res.dest_column = CoordInW'(tc);
            end
          end
        end
      end
    end
    return res;
  endfunction

  task automatic send_item(cmd_e cmd, logic [CoordInW-1:0] r, logic [CoordInW-1:0] c,
                           mat_e mat, logic side);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    row_i         <= r;
    column_i      <= c;
    material_i    <= mat;
    side_choice_i <= side;
    do @(posedge clk_i); while (!in_ready_o);
    outcome_q.push_back(apply_command(cmd, r, c, mat, side));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgDensSand:  sand_density  = data;
      CfgDensWater: water_density = data;
      CfgDensSolid: solid_density = data;
      CfgStatMask:  pinned_mask   = data[NibW-1:0];
      CfgSpread:    spread_limit  = data[NibW-1:0];
      default: ;
    endcase
  endtask

  // Upper bits of the nibble registers carry noise; also poke an unused index
  task automatic program_registers(logic [DensW-1:0] sand, logic [DensW-1:0] water,
                                   logic [DensW-1:0] solid, logic [NibW-1:0] mask,
                                   logic [NibW-1:0] spread);
    write_reg(CfgDensSand, sand);
    write_reg(CfgDensWater, water);
    write_reg(CfgDensSolid, solid);
    write_reg(CfgStatMask, {4'($urandom), mask});
    write_reg(CfgSpread, {4'($urandom), spread});
    write_reg(CfgIdxW'(CfgSpread + 1 + $urandom_range(2)), 8'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Work mostly inside a small window so cells pile up and interact
  task automatic run_random_block(int unsigned count);
    int unsigned         base_r;
    int unsigned         base_c;
    int unsigned         roll;
    logic [CoordInW-1:0] r;
    logic [CoordInW-1:0] c;
    cmd_e                cmd;
    mat_e                mat;
    base_r = 56;
    base_c = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        base_r = ($urandom_range(1) == 0) ? 56 : $urandom_range(56);
        roll   = $urandom_range(2);
        base_c = (roll == 0) ? 0 : (roll == 1) ? 56 : $urandom_range(56);
      end
      if ($urandom_range(99) < 85) begin
        r = CoordInW'(base_r + $urandom_range(7));
        c = CoordInW'(base_c + $urandom_range(7));
      end else begin
        r = CoordInW'($urandom);
        c = CoordInW'($urandom);
      end
      roll = $urandom_range(99);
      cmd  = (roll < 35) ? CmdWrite : (roll < 80) ? CmdUpdate : (roll < 95) ? CmdRead : CmdSpare;
      roll = $urandom_range(9);
      mat  = (roll < 3) ? MatSand : (roll < 6) ? MatWater : (roll < 8) ? MatSolid : MatEmpty;
      send_item(cmd, r, c, mat, 1'($urandom));
    end
  endtask

  task automatic test_directed_cases();
    send_item(CmdRead,   6'd0,  6'd0,  MatSolid, 1'b1);
    // sand on the floor stays put
    send_item(CmdWrite,  6'd63, 6'd0,  MatSand,  1'b0);
    send_item(CmdUpdate, 6'd63, 6'd0,  MatEmpty, 1'b0);
    // blocked below, minus side off the grid, falls to the other diagonal
    send_item(CmdWrite,  6'd62, 6'd0,  MatSand,  1'b0);
    send_item(CmdUpdate, 6'd62, 6'd0,  MatWater, 1'b0);
    send_item(CmdWrite,  6'd62, 6'd63, MatWater, 1'b1);
    send_item(CmdWrite,  6'd63, 6'd63, MatSolid, 1'b1);
    send_item(CmdUpdate, 6'd62, 6'd63, MatSand,  1'b1);
    // water on the floor, blocked by the solid, spreads sideways to the other side
    send_item(CmdUpdate, 6'd63, 6'd62, MatEmpty, 1'b1);
    // sand sinks through water
    send_item(CmdWrite,  6'd10, 6'd5,  MatSand,  1'b1);
    send_item(CmdWrite,  6'd11, 6'd5,  MatWater, 1'b0);
    send_item(CmdUpdate, 6'd10, 6'd5,  MatSolid, 1'b1);
    send_item(CmdRead,   6'd10, 6'd5,  MatEmpty, 1'b0);
    // solid and empty cells never move
    send_item(CmdWrite,  6'd20, 6'd20, MatSolid, 1'b0);
    send_item(CmdUpdate, 6'd20, 6'd20, MatSand,  1'b0);
    send_item(CmdUpdate, 6'd30, 6'd30, MatWater, 1'b1);
    send_item(CmdSpare,  6'd20, 6'd20, MatEmpty, 1'b1);
    send_item(CmdWrite,  6'd0,  6'd63, MatWater, 1'b1);
    send_item(CmdUpdate, 6'd0,  6'd63, MatEmpty, 1'b1);
    send_item(CmdRead,   6'd1,  6'd63, MatSand,  1'b0);
    send_item(CmdWrite,  6'd63, 6'd63, MatEmpty, 1'b0);
    send_item(CmdRead,   6'd63, 6'd63, MatSolid, 1'b1);
  endtask

  task automatic test_extreme_settings();
    wait_for_results();
    program_registers(8'd0, 8'd0, 8'd0, 4'd0, 4'd0);
    run_random_block(230);
    wait_for_results();
    program_registers(8'd255, 8'd255, 8'd255, 4'hF, 4'hF);
    run_random_block(230);
  endtask

  // Water heavier than sand, solid light and displaceable
  task automatic test_inverted_densities();
    wait_for_results();
    program_registers(8'd20, 8'd240, 8'd0, 4'd0, 4'hF);
    run_random_block(230);
  endtask

  task automatic test_random_settings(int unsigned blocks);
    for (int unsigned b = 0; b < blocks; b++) begin
      wait_for_results();
      program_registers(8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom), 4'($urandom));
      run_random_block(115);
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : take_results
    outcome_t want;
    if (out_valid_o && out_ready_i) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %0d %0d %0d %0d", $time,
                 cell_material_o, moved_o, dest_row_o, dest_column_o);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        check_field("cell_material", 8'(want.cell_material), 8'(cell_material_o));
        check_field("moved", 8'(want.moved), 8'(moved_o));
        check_field("dest_row", 8'(want.dest_row), 8'(dest_row_o));
        check_field("dest_column", 8'(want.dest_column), 8'(dest_column_o));
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    for (int r = 0; r < GridRows; r++)
      for (int c = 0; c < GridColumns; c++)
        grid_model[r][c] = MatEmpty;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    gap_pct   = 7;
    stall_pct = 61;
    test_directed_cases();
    test_extreme_settings();

    gap_pct   = 61;
    stall_pct = 7;
    test_inverted_densities();
    test_random_settings(2);

    gap_pct   = 0;
    stall_pct = 0;
    test_random_settings(4);

    wait_for_results();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("falling_sand_cell_update_tb: done, clean");
    end else begin
      $display("falling_sand_cell_update_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("falling_sand_cell_update_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fsc_pkg.sv
rtl/fsc_cfg.sv
rtl/fsc_grid_mem.sv
rtl/fsc_ctrl.sv
rtl/falling_sand_cell_update.sv
sim/falling_sand_cell_update_tb.sv
